[hdl/lcg_pkg.sv]
// Package for the line colour gradient block: widths, reset values, register map.
// No dependencies; imported by the interfaces and by every module.
`default_nettype none

package lcg_pkg;

    localparam int LCG_POS_WIDTH  = 12;  // default position / length width
    localparam int LCG_CH_WIDTH   = 8;   // bits per color channel
    localparam int LCG_NUM_CH     = 3;   // R, G, B
    localparam int LCG_RGB_WIDTH  = LCG_NUM_CH * LCG_CH_WIDTH;
    localparam int LCG_ALT_WIDTH  = 16;

    // APB register map: one 32-bit register per word
    localparam int LCG_APB_AW     = 3;
    localparam int LCG_APB_DW     = 32;

    localparam logic LCG_REG_BASE_COLOUR = 1'b0;  // word index of base_colour

    localparam logic [LCG_RGB_WIDTH-1:0] LCG_BASE_RESET = 24'hFF_FFFF;

endpackage

`default_nettype wire

[hdl/lcg_if.sv]
// Valid/ready channel interfaces for the line colour gradient block.
// Depends on lcg_pkg for field widths.
`default_nettype none

interface lcg_in_if
    import lcg_pkg::*;
    #(parameter int POS_W = LCG_POS_WIDTH) ();

    logic                            valid;
    logic                            ready;
    logic        [LCG_RGB_WIDTH-1:0] colour_a;
    logic        [LCG_RGB_WIDTH-1:0] colour_b;
    logic signed [LCG_ALT_WIDTH-1:0] altitude_a;
    logic signed [LCG_ALT_WIDTH-1:0] altitude_b;
    logic        [POS_W-1:0]         position;
    logic        [POS_W-1:0]         length;

    modport source (
        output valid, colour_a, colour_b, altitude_a, altitude_b, position, length,
        input  ready
    );

    modport sink (
        input  valid, colour_a, colour_b, altitude_a, altitude_b, position, length,
        output ready
    );

endinterface

interface lcg_out_if
    import lcg_pkg::*;
    ();

    logic                     valid;
    logic                     ready;
    logic [LCG_RGB_WIDTH-1:0] pixel_colour;

    modport source (
        output valid, pixel_colour,
        input  ready
    );

    modport sink (
        input  valid, pixel_colour,
        output ready
    );

endinterface

`default_nettype wire

[hdl/line_colour_gradient_core.sv]
// Line colour gradient top level: APB base-color register, entry stage, divider cell chain.
// Depends on lcg_pkg, lcg_if, lcg_prep and lcg_div_cell.
//
// Usage:
//   in_ch  (valid/ready) carries one pixel item: endpoint colors, altitudes,
//          pixel position and line length. An item is taken when valid && ready.
//   out_ch (valid/ready) returns the blended RGB888 pixel_colour, in order.
//   APB port holds base_colour at byte address 0; write only while idle.
// Datapath: one entry stage builds a*(len-pos)+b*pos per channel, then a
//   row of 8 restoring-divider cells settles one quotient bit each, MSB first,
//   all three channels side by side. Equal colors or zero length enter the
//   chain as color A over a divisor of one.
// Path: the entry stage loads an item at the accept edge, then each of the 8 cells
//   registers it in turn; out_ch.valid rises once the last cell holds it.
// Throughput: one item per cycle while out_ch keeps taking results; the cell count is set by the 8-bit channel.
// Each stage has its own valid bit and ready = !valid || downstream ready, so
//   bubbles close up and new items keep entering while a result waits at the
//   output; in_ch.ready drops only when every stage is full and out_ch stalls.
// Reset (synchronous, active low) empties all stages and sets base_colour
//   to white.
`default_nettype none

module line_colour_gradient_core
    import lcg_pkg::*;
#(
    parameter int POSITION_WIDTH = LCG_POS_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    lcg_in_if.sink                       in_ch,
    lcg_out_if.source                    out_ch,
    input  wire logic                    i_psel,
    input  wire logic                    i_penable,
    input  wire logic                    i_pwrite,
    input  wire logic [LCG_APB_AW-1:0]   i_paddr,
    input  wire logic [LCG_APB_DW-1:0]   i_pwdata,
    output logic      [LCG_APB_DW-1:0]   o_prdata,
    output logic                         o_pready
);

    localparam int NUM_W  = POSITION_WIDTH + LCG_CH_WIDTH;
    localparam int NCELLS = LCG_CH_WIDTH;

    // ---------------- configuration register ----------------
    logic [LCG_RGB_WIDTH-1:0] r_base_colour;
    logic                     cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_colour <= LCG_BASE_RESET;
        end else if (cfg_wr && (i_paddr[2] == LCG_REG_BASE_COLOUR)) begin
            r_base_colour <= i_pwdata[LCG_RGB_WIDTH-1:0];
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            LCG_REG_BASE_COLOUR: o_prdata = LCG_APB_DW'(r_base_colour);
            default:             o_prdata = '0;
        endcase
    end

    // ---------------- stage wiring: index 0 is the entry stage ----------------
    logic [NCELLS:0]                                      st_valid;
    logic [NCELLS:0]                                      dn_ready;
    logic [NCELLS:0][LCG_NUM_CH-1:0][NUM_W-1:0]           st_rem;
    logic [NCELLS:0][LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0]    st_quo;
    logic [NCELLS:0][POSITION_WIDTH-1:0]                  st_len;

    assign st_quo[0]        = '0;   // quotient bits start cleared
    assign dn_ready[NCELLS] = out_ch.ready;

    lcg_prep #(
        .POS_W (POSITION_WIDTH)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_ch.valid),
        .o_ready      (in_ch.ready),
        .i_colour_a   (in_ch.colour_a),
        .i_colour_b   (in_ch.colour_b),
        .i_altitude_a (in_ch.altitude_a),
        .i_altitude_b (in_ch.altitude_b),
        .i_position   (in_ch.position),
        .i_length     (in_ch.length),
        .i_base_colour(r_base_colour),
        .o_valid      (st_valid[0]),
        .i_ready      (dn_ready[0]),
        .o_num        (st_rem[0]),
        .o_len        (st_len[0])
    );

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        lcg_div_cell #(
            .POS_W   (POSITION_WIDTH),
            .BIT_IDX (NCELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k]),
            .o_ready (dn_ready[k]),
            .i_rem   (st_rem[k]),
            .i_quo   (st_quo[k]),
            .i_len   (st_len[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (dn_ready[k+1]),
            .o_rem   (st_rem[k+1]),
            .o_quo   (st_quo[k+1]),
            .o_len   (st_len[k+1])
        );
    end

    // last cell doubles as the output register
    assign out_ch.valid        = st_valid[NCELLS];
    assign out_ch.pixel_colour = st_quo[NCELLS];

`ifndef NO_ASSERTIONS
    // the entry stage never hands the chain a zero divisor
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_valid[0] |-> (st_len[0] != '0))
        else $error("zero divisor entered the divider chain");

    // a finished division leaves a remainder below the divisor on every channel
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_valid[NCELLS] |->
            (st_rem[NCELLS][0] < NUM_W'(st_len[NCELLS])) &&
            (st_rem[NCELLS][1] < NUM_W'(st_len[NCELLS])) &&
            (st_rem[NCELLS][2] < NUM_W'(st_len[NCELLS])))
        else $error("divider remainder not below divisor");

    // an accepted item always occupies the entry stage on the next cycle
    a_accept_fills_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> st_valid[0])
        else $error("accepted item lost at entry stage");
`endif

endmodule

`default_nettype wire

[hdl/lcg_prep.sv]
// Entry stage: base-color substitution, position clamp and per-channel numerators, or a divide-by-one bypass.
// Depends on lcg_pkg.
`default_nettype none

module lcg_prep
    import lcg_pkg::*;
#(
    parameter  int POS_W = LCG_POS_WIDTH,
    localparam int NUM_W = POS_W + LCG_CH_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [LCG_RGB_WIDTH-1:0]               i_colour_a,
    input  wire logic [LCG_RGB_WIDTH-1:0]               i_colour_b,
    input  wire logic [LCG_ALT_WIDTH-1:0]               i_altitude_a,
    input  wire logic [LCG_ALT_WIDTH-1:0]               i_altitude_b,
    input  wire logic [POS_W-1:0]                       i_position,
    input  wire logic [POS_W-1:0]                       i_length,
    input  wire logic [LCG_RGB_WIDTH-1:0]               i_base_colour,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [LCG_NUM_CH-1:0][NUM_W-1:0]            o_num,
    output logic [POS_W-1:0]                            o_len
);

    logic                                r_valid;
    logic [LCG_NUM_CH-1:0][NUM_W-1:0]    r_num;
    logic [POS_W-1:0]                    r_len;
    logic [LCG_NUM_CH-1:0][NUM_W-1:0]    n_num;
    logic [POS_W-1:0]                    n_len;

    logic                                    bypass;
    logic                                    zero_a;
    logic                                    zero_b;
    logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0] col_a;
    logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0] col_b;
    logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0] raw_a;
    logic [POS_W-1:0]                        pos_sat;
    logic [POS_W-1:0]                        len_m_pos;
    logic                                    advance;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_comb begin
        raw_a   = i_colour_a;
        bypass  = (i_colour_a == i_colour_b) || (i_length == '0);
        zero_a  = (i_altitude_a == '0);
        zero_b  = (i_altitude_b == '0);
        // a grounded endpoint takes the base color only if its partner is raised
        col_a   = (zero_a && !zero_b) ? i_base_colour : i_colour_a;
        col_b   = (zero_b && !zero_a) ? i_base_colour : i_colour_b;
        pos_sat = (i_position > i_length) ? i_length : i_position;
        len_m_pos = i_length - pos_sat;
        for (int ch = 0; ch < LCG_NUM_CH; ch++) begin
            if (bypass) begin
                // divide by one passes color A straight through the chain
                n_num[ch] = NUM_W'(raw_a[ch]);
            end else begin
                n_num[ch] = NUM_W'(col_a[ch]) * NUM_W'(len_m_pos)
                          + NUM_W'(col_b[ch]) * NUM_W'(pos_sat);
            end
        end
        n_len = bypass ? POS_W'(1) : i_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_num <= n_num;
            r_len <= n_len;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_len   = r_len;

endmodule

`default_nettype wire

[hdl/lcg_div_cell.sv]
// One restoring-division cell: settles one quotient bit for all three channels.
// Depends on lcg_pkg.
`default_nettype none

module lcg_div_cell
    import lcg_pkg::*;
#(
    parameter  int POS_W   = LCG_POS_WIDTH,
    parameter  int BIT_IDX = 0,
    localparam int NUM_W   = POS_W + LCG_CH_WIDTH
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    output logic                                           o_ready,
    input  wire logic [LCG_NUM_CH-1:0][NUM_W-1:0]          i_rem,
    input  wire logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0]   i_quo,
    input  wire logic [POS_W-1:0]                          i_len,
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic [LCG_NUM_CH-1:0][NUM_W-1:0]               o_rem,
    output logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0]        o_quo,
    output logic [POS_W-1:0]                               o_len
);

    logic                                    r_valid;
    logic [LCG_NUM_CH-1:0][NUM_W-1:0]        r_rem;
    logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0] r_quo;
    logic [POS_W-1:0]                        r_len;
    logic [LCG_NUM_CH-1:0][NUM_W-1:0]        n_rem;
    logic [LCG_NUM_CH-1:0][LCG_CH_WIDTH-1:0] n_quo;
    logic [NUM_W-1:0]                        divisor;
    logic                                    advance;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;
    assign divisor = NUM_W'(i_len) << BIT_IDX;

    always_comb begin
        for (int ch = 0; ch < LCG_NUM_CH; ch++) begin
            if (i_rem[ch] >= divisor) begin
                n_rem[ch] = i_rem[ch] - divisor;
                n_quo[ch] = i_quo[ch] | (LCG_CH_WIDTH'(1) << BIT_IDX);
            end else begin
                n_rem[ch] = i_rem[ch];
                n_quo[ch] = i_quo[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_len <= i_len;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_len   = r_len;

endmodule

`default_nettype wire

[verif/line_colour_gradient_core_tb.sv]
// Testbench for line_colour_gradient_core: directed and random pixel items checked
// against an in-bench blend predictor. Depends on lcg_pkg, lcg_if and the core RTL.

module line_colour_gradient_core_tb;
    import lcg_pkg::*;

    localparam int PIPE_LATENCY = 9;    // entry stage + 8 divider cells
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 150;  // long output stall, fills every stage
    localparam logic [LCG_APB_AW-1:0] BASE_COLOUR_ADDR = LCG_APB_AW'(4 * LCG_REG_BASE_COLOUR);
    localparam logic [LCG_RGB_WIDTH-1:0] WHITE = 24'hFF_FFFF;
    localparam logic [LCG_RGB_WIDTH-1:0] BLACK = 24'h00_0000;

    typedef logic [LCG_RGB_WIDTH-1:0] rgb_t;
    typedef logic [LCG_POS_WIDTH-1:0] pos_t;

    typedef struct packed {
        rgb_t                            colour_a;
        rgb_t                            colour_b;
        logic signed [LCG_ALT_WIDTH-1:0] altitude_a;
        logic signed [LCG_ALT_WIDTH-1:0] altitude_b;
        pos_t                            position;
        pos_t                            length;
    } pixel_t;

    logic i_clk;
    logic i_rst_n;

    logic                  apb_psel;
    logic                  apb_penable;
    logic                  apb_pwrite;
    logic [LCG_APB_AW-1:0] apb_paddr;
    logic [LCG_APB_DW-1:0] apb_pwdata;
    logic [LCG_APB_DW-1:0] apb_prdata;
    logic                  apb_pready;

    lcg_in_if #(.POS_W(LCG_POS_WIDTH)) in_bus ();
    lcg_out_if                         out_bus ();

    // Shadow of the base colour register, updated on each write
    rgb_t base_colour_shadow;
    // Blended colours still owed by the block, oldest first
    rgb_t expected_colours[$];

    int   error_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_off;
    event hold_start;

    line_colour_gradient_core #(
        .POSITION_WIDTH (LCG_POS_WIDTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_bus),
        .out_ch    (out_bus),
        .i_psel    (apb_psel),
        .i_penable (apb_penable),
        .i_pwrite  (apb_pwrite),
        .i_paddr   (apb_paddr),
        .i_pwdata  (apb_pwdata),
        .o_prdata  (apb_prdata),
        .o_pready  (apb_pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Blend one pixel: equal colours or zero length pass colour A through,
    // otherwise a zero-altitude endpoint opposite a raised one takes the base
    // colour, position saturates at length, and each channel is
    // floor((a*(len-pos) + b*pos) / len).
    function automatic rgb_t blend_pixel(input pixel_t px, input rgb_t base);
        rgb_t        ca;
        rgb_t        cb;
        pos_t        pos;
        int unsigned num;
        rgb_t        res;
        ca  = px.colour_a;
        cb  = px.colour_b;
        pos = px.position;
        if (ca == cb || px.length == 0)
            return ca;
        if (px.altitude_a == 0 && px.altitude_b != 0)
            ca = base;
        if (px.altitude_b == 0 && px.altitude_a != 0)
            cb = base;
        if (pos > px.length)
            pos = px.length;
        res = '0;
        for (int ch = 0; ch < LCG_NUM_CH; ch++) begin
            num = int'(ca[ch*LCG_CH_WIDTH +: LCG_CH_WIDTH]) * int'(px.length - pos)
                + int'(cb[ch*LCG_CH_WIDTH +: LCG_CH_WIDTH]) * int'(pos);
            res[ch*LCG_CH_WIDTH +: LCG_CH_WIDTH] = LCG_CH_WIDTH'(num / int'(px.length));
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(input rgb_t ca, input rgb_t cb,
                                          input int alt_a, input int alt_b,
                                          input int pos, input int len);
        pixel_t px;
        px.colour_a   = ca;
        px.colour_b   = cb;
        px.altitude_a = LCG_ALT_WIDTH'(alt_a);
        px.altitude_b = LCG_ALT_WIDTH'(alt_b);
        px.position   = LCG_POS_WIDTH'(pos);
        px.length     = LCG_POS_WIDTH'(len);
        return px;
    endfunction

    function automatic logic signed [LCG_ALT_WIDTH-1:0] random_altitude();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return '0;
        if (pick == 3)
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return LCG_ALT_WIDTH'($urandom);
    endfunction

    // Mostly well-formed pixels along a line; some equal colours, zero
    // lengths and positions past the end mixed in.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     pick;
        px.colour_a   = LCG_RGB_WIDTH'($urandom);
        px.colour_b   = ($urandom_range(9) == 0) ? px.colour_a : LCG_RGB_WIDTH'($urandom);
        px.altitude_a = random_altitude();
        px.altitude_b = random_altitude();
        pick = $urandom_range(99);
        if (pick < 5)
            px.length = '0;
        else if (pick < 30)
            px.length = LCG_POS_WIDTH'($urandom_range(1, 16));
        else if (pick < 35)
            px.length = '1;
        else
            px.length = LCG_POS_WIDTH'($urandom_range(1, (1 << LCG_POS_WIDTH) - 1));
        if ($urandom_range(99) < 80)
            px.position = LCG_POS_WIDTH'($urandom_range(0, int'(px.length)));
        else
            px.position = LCG_POS_WIDTH'($urandom);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item and hold it until taken; optionally drop valid for a gap.
    // valid is never lowered here unless a gap follows, so back-to-back items
    // keep it high.
    task automatic send_pixel(input pixel_t px);
        in_bus.valid      <= 1'b1;
        in_bus.colour_a   <= px.colour_a;
        in_bus.colour_b   <= px.colour_b;
        in_bus.altitude_a <= px.altitude_a;
        in_bus.altitude_b <= px.altitude_b;
        in_bus.position   <= px.position;
        in_bus.length     <= px.length;
        do @(posedge i_clk); while (!in_bus.ready);
        expected_colours.push_back(blend_pixel(px, base_colour_shadow));
        if ($urandom_range(99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_pixels(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(random_pixel());
    endtask

    // Stop offering items and wait until every owed colour has come back,
    // then let the pipeline settle.
    task automatic wait_for_results();
        in_bus.valid <= 1'b0;
        while (expected_colours.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_base_colour(input rgb_t value);
        apb_psel    <= 1'b1;
        apb_penable <= 1'b0;
        apb_pwrite  <= 1'b1;
        apb_paddr   <= BASE_COLOUR_ADDR;
        apb_pwdata  <= LCG_APB_DW'(value);
        @(posedge i_clk);
        apb_penable <= 1'b1;
        do @(posedge i_clk); while (!apb_pready);
        apb_psel    <= 1'b0;
        apb_penable <= 1'b0;
        base_colour_shadow = value;
    endtask

    task automatic report_error(input string what, input rgb_t want, input rgb_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR: %s: expected %06h got %06h", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Endpoints of the blend and field extremes, all altitudes non-zero.
    task automatic test_blend_extremes();
        send_pixel(make_pixel(BLACK, WHITE, 5, 5, 0, 4095));
        send_pixel(make_pixel(BLACK, WHITE, 1, 1, 4095, 4095));
        send_pixel(make_pixel(WHITE, BLACK, -32768, 32767, 2048, 4095));
        send_pixel(make_pixel(24'h12_3456, 24'h65_4321, 1, 1, 1, 1));
        send_pixel(make_pixel(BLACK, WHITE, -1, -1, 1, 3));
        send_pixel(make_pixel(WHITE, 24'hFF_FFFE, 32767, 32767, 4094, 4095));
    endtask

    // Zero-altitude endpoint opposite a raised one takes the base colour;
    // both zero or both raised leave the colours alone.
    task automatic test_base_substitution();
        send_pixel(make_pixel(24'h10_2030, 24'h40_5060, 0, 100, 2, 4));
        send_pixel(make_pixel(24'h10_2030, 24'h40_5060, -5, 0, 1, 4));
        send_pixel(make_pixel(24'h10_2030, 24'h40_5060, 0, 0, 1, 2));
        send_pixel(make_pixel(24'h10_2030, 24'h40_5060, -32768, 32767, 1, 2));
        send_pixel(make_pixel(BLACK, 24'h00_0001, 0, -32768, 4095, 4095));
    endtask

    // Equal colours pass colour A through whatever the altitudes.
    task automatic test_equal_colours();
        send_pixel(make_pixel(24'hAB_CDEF, 24'hAB_CDEF, 0, 7, 3, 9));
        send_pixel(make_pixel(BLACK, BLACK, 32767, 0, 4095, 1));
    endtask

    // Zero length: colour A as given, no substitution.
    task automatic test_zero_length();
        send_pixel(make_pixel(24'h11_2233, 24'h44_5566, 0, 9, 5, 0));
        send_pixel(make_pixel(WHITE, BLACK, 0, 0, 0, 0));
        send_pixel(make_pixel(BLACK, WHITE, 3, 0, 4095, 0));
    endtask

    // Position beyond length clamps to length (colour B).
    task automatic test_position_past_end();
        send_pixel(make_pixel(24'h00_FF00, 24'hFF_0000, 1, 1, 4095, 100));
        send_pixel(make_pixel(24'h00_FF00, 24'hFF_0000, 1, 1, 101, 100));
        send_pixel(make_pixel(24'h80_8080, 24'h7F_7F7F, 0, 2, 2, 1));
    endtask

    // Random traffic under one base colour and one idling mix.
    task automatic test_random_traffic(input rgb_t base, input int count,
                                       input int tx_pct, input int rx_pct);
        wait_for_results();
        write_base_colour(base);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_random_pixels(count);
    endtask

    // Output held off for a long stretch while items keep coming, so every
    // stage fills and the input stalls.
    task automatic test_output_backpressure();
        wait_for_results();
        tx_idle_pct = 0;
        rx_idle_pct = 27;
        -> hold_start;
        send_random_pixels(60);
    endtask

    // ------------------------------------------------------------------
    // Processes
    // ------------------------------------------------------------------

    // Result monitor: checks each taken colour against the oldest expected
    // one, then picks the next ready value.
    initial begin : result_monitor
        rgb_t want;
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid && out_bus.ready) begin
                if (expected_colours.size() == 0) begin
                    report_error("unexpected pixel_colour", 'x, out_bus.pixel_colour);
                end else begin
                    want = expected_colours.pop_front();
                    if (out_bus.pixel_colour !== want)
                        report_error("pixel_colour mismatch", want, out_bus.pixel_colour);
                end
            end
            out_bus.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long output stall, counted in cycles here
    initial begin : output_hold_timer
        hold_off = 1'b0;
        forever begin
            @(hold_start);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    initial begin : watchdog
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial begin : test_sequence
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        apb_psel           = 1'b0;
        apb_penable        = 1'b0;
        apb_pwrite         = 1'b0;
        apb_paddr          = '0;
        apb_pwdata         = '0;
        in_bus.valid       = 1'b0;
        in_bus.colour_a    = '0;
        in_bus.colour_b    = '0;
        in_bus.altitude_a  = '0;
        in_bus.altitude_b  = '0;
        in_bus.position    = '0;
        in_bus.length      = '0;
        base_colour_shadow = LCG_BASE_RESET;
        error_count        = 0;
        tx_idle_pct        = 27;
        rx_idle_pct        = 27;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items run with the reset base colour (white)
        test_blend_extremes();
        test_base_substitution();
        test_equal_colours();
        test_zero_length();
        test_position_past_end();

        test_random_traffic(LCG_BASE_RESET, 400, 27, 27);
        test_random_traffic(BLACK, 400, 0, 0);        // no idling at all
        test_output_backpressure();
        test_random_traffic(LCG_RGB_WIDTH'($urandom), 400, 27, 27);
        test_random_traffic(WHITE, 300, 27, 27);
        test_random_traffic(LCG_RGB_WIDTH'($urandom), 390, 27, 27);

        wait_for_results();
        if (error_count == 0 && expected_colours.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[line_colour_gradient_core.f]
hdl/lcg_pkg.sv
hdl/lcg_if.sv
hdl/lcg_prep.sv
hdl/lcg_div_cell.sv
hdl/line_colour_gradient_core.sv
verif/line_colour_gradient_core_tb.sv
